@@ design/agc_pkg.sv @@
// Package for the anagram group classifier: sizes, FSM type and the cell link type.
// Used by agc_hist, agc_cell, the top level and the testbench.
`default_nettype none
package agc_pkg;
    localparam int ALPHABET_SIZE = 128;
    localparam int MAX_GROUPS    = 16;
    localparam int MAX_WORD_LEN  = 63;
    localparam int ADDR_W        = $clog2(ALPHABET_SIZE);
    localparam int SWEEP_W       = $clog2(ALPHABET_SIZE + 1);
    localparam int CNT_W         = 6;
    localparam int GID_W         = $clog2(MAX_GROUPS + 1);
    localparam int DRAIN_CYCLES  = MAX_GROUPS + 3;
    localparam int DRAIN_W       = $clog2(DRAIN_CYCLES + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
    } link_t;
endpackage
`default_nettype wire

@@ design/agc_hist.sv @@
// Histogram memory of the current word, one count per character code.
// Depends on agc_pkg.
`default_nettype none
module agc_hist
    import agc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic              wr_en,
    input  wire logic [CNT_W-1:0]  wdata,
    output logic      [CNT_W-1:0]  rdata_reg
);
    logic [CNT_W-1:0] mem [ALPHABET_SIZE];

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end
endmodule
`default_nettype wire

@@ design/agc_cell.sv @@
// One group cell: holds a signature, compares it with the passing histogram and hands it on.
// Depends on agc_pkg.
`default_nettype none
module agc_cell
    import agc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire link_t link_in,
    input  wire logic  wr_sel,
    output link_t      link_out,
    output logic       mismatch
);
    logic [CNT_W-1:0] sig_mem [ALPHABET_SIZE];
    logic [CNT_W-1:0] rd_reg;
    link_t            link_reg;
    logic             mismatch_reg;
    logic             mismatch_next;
    logic             differ;

    always_ff @(posedge clk)
    begin
        rd_reg <= sig_mem[link_in.addr];
        if (link_in.valid && wr_sel)
        begin
            sig_mem[link_in.addr] <= link_in.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg     <= '0;
            mismatch_reg <= 1'b0;
        end
        else
        begin
            link_reg     <= link_in;
            mismatch_reg <= mismatch_next;
        end
    end

    always_comb
    begin
        differ        = (rd_reg != link_reg.count);
        mismatch_next = mismatch_reg;
        if (link_reg.valid)
        begin
            mismatch_next = link_reg.first ? differ : (mismatch_reg | differ);
        end
    end

    assign link_out = link_reg;
    assign mismatch = mismatch_reg;
endmodule
`default_nettype wire

@@ design/anagram_group_classifier.sv @@
// Top level of the anagram group classifier: input control, histogram, row of group cells.
// Depends on agc_pkg, agc_hist and agc_cell.
// After reset the histogram is cleared in a pass over all ALPHABET_SIZE codes, during
// which no character is accepted. Each character has its histogram count read and then
// updated before the next one is accepted. After the last character of a word the
// histogram is swept out through the row of group cells, one code per cycle, and the
// row drains before the result is registered; the sweep also clears the histogram for
// the next word.
`default_nettype none
module anagram_group_classifier
    import agc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // char_code[6:0], zero pad[7]
    input  wire logic       s_axis_tlast,   // last_char
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic      [7:0] m_axis_tdata    // group_index[3:0], new_group[4],
                                            // table_full[5], word_too_long[6], zero pad[7]
);
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    code_reg, code_next;
    logic                 last_reg, last_next;
    logic                 ovf_reg, ovf_next;
    logic [SWEEP_W-1:0]   sweep_reg, sweep_next;
    logic [DRAIN_W-1:0]   drain_reg, drain_next;
    logic [GID_W-1:0]     gcount_reg, gcount_next;
    logic                 inj_valid_reg, inj_valid_next;
    logic                 inj_first_reg, inj_first_next;
    logic [ADDR_W-1:0]    inj_addr_reg, inj_addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [6:0]           out_data_reg, out_data_next;

    logic [ADDR_W-1:0]    h_addr;
    logic                 h_wr;
    logic [CNT_W-1:0]     h_wdata;
    logic [CNT_W-1:0]     h_rdata;

    link_t                chain [MAX_GROUPS+1];
    logic [MAX_GROUPS-1:0] mismatch;
    logic [MAX_GROUPS-1:0] wr_sel;
    logic                 found;
    logic [GID_W-1:0]     match_idx;

    agc_hist u_hist (
        .clk       (clk),
        .addr      (h_addr),
        .wr_en     (h_wr),
        .wdata     (h_wdata),
        .rdata_reg (h_rdata)
    );

    assign chain[0] = '{valid: inj_valid_reg, first: inj_first_reg,
                        addr: inj_addr_reg, count: h_rdata};

    for (genvar k = 0; k < MAX_GROUPS; k++)
    begin : g_cell
        assign wr_sel[k] = (gcount_reg == GID_W'(k));
        agc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (chain[k]),
            .wr_sel   (wr_sel[k]),
            .link_out (chain[k+1]),
            .mismatch (mismatch[k])
        );
    end

    always_comb
    begin
        found     = 1'b0;
        match_idx = '0;
        for (int k = MAX_GROUPS - 1; k >= 0; k--)
        begin
            if (GID_W'(k) < gcount_reg && !mismatch[k])
            begin
                found     = 1'b1;
                match_idx = GID_W'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            code_reg      <= '0;
            last_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            sweep_reg     <= '0;
            drain_reg     <= '0;
            gcount_reg    <= '0;
            inj_valid_reg <= 1'b0;
            inj_first_reg <= 1'b0;
            inj_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            last_reg      <= last_next;
            ovf_reg       <= ovf_next;
            sweep_reg     <= sweep_next;
            drain_reg     <= drain_next;
            gcount_reg    <= gcount_next;
            inj_valid_reg <= inj_valid_next;
            inj_first_reg <= inj_first_next;
            inj_addr_reg  <= inj_addr_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        sweep_next     = sweep_reg;
        drain_next     = drain_reg;
        gcount_next    = gcount_reg;
        inj_valid_next = 1'b0;
        inj_first_next = 1'b0;
        inj_addr_next  = inj_addr_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        s_axis_tready  = 1'b0;
        h_addr         = code_reg;
        h_wr           = 1'b0;
        h_wdata        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                h_addr     = sweep_reg[ADDR_W-1:0];
                h_wr       = 1'b1;
                sweep_next = sweep_reg + SWEEP_W'(1);
                if (sweep_reg == SWEEP_W'(ALPHABET_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                h_addr        = s_axis_tdata[ADDR_W-1:0];
                if (s_axis_tvalid)
                begin
                    code_next  = s_axis_tdata[ADDR_W-1:0];
                    last_next  = s_axis_tlast;
                    state_next = ST_INC;
                end
            end
            ST_INC:
            begin
                h_wr = 1'b1;
                if (h_rdata >= CNT_W'(MAX_WORD_LEN))
                begin
                    h_wdata  = h_rdata;
                    ovf_next = 1'b1;
                end
                else
                begin
                    h_wdata = h_rdata + CNT_W'(1);
                end
                sweep_next = '0;
                state_next = last_reg ? ST_SWEEP : ST_IDLE;
            end
            ST_SWEEP:
            begin
                h_addr         = sweep_reg[ADDR_W-1:0];
                h_wr           = 1'b1;
                inj_valid_next = 1'b1;
                inj_first_next = (sweep_reg == '0);
                inj_addr_next  = sweep_reg[ADDR_W-1:0];
                sweep_next     = sweep_reg + SWEEP_W'(1);
                if (sweep_reg == SWEEP_W'(ALPHABET_SIZE - 1))
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    if (found)
                    begin
                        out_data_next = {ovf_reg, 1'b0, 1'b0, match_idx[3:0]};
                    end
                    else if (gcount_reg < GID_W'(MAX_GROUPS))
                    begin
                        out_data_next = {ovf_reg, 1'b0, 1'b1, gcount_reg[3:0]};
                        gcount_next   = gcount_reg + GID_W'(1);
                    end
                    else
                    begin
                        out_data_next = {ovf_reg, 1'b1, 1'b0, 4'd0};
                    end
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};
endmodule
`default_nettype wire

@@ design/agc_checker.sv @@
// Port checker for the anagram group classifier, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module agc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");
    a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> !m_axis_tdata[4] && m_axis_tdata[3:0] == 4'd0)
        else $error("table full result carries a group");
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[7])
        else $error("pad bit set");
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("character accepted on consecutive cycles");
endmodule

bind anagram_group_classifier agc_checker u_agc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ test/tb_anagram_group_classifier.sv @@
// Testbench for anagram_group_classifier: streams words as characters and checks each group result
// against a histogram-based predictor. Depends on agc_pkg and the design files only.
`default_nettype none
module tb_anagram_group_classifier;
    import agc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0] group_index;
        logic       new_group;
        logic       table_full;
        logic       word_too_long;
    } group_result_t;

    localparam int STALL_LIMIT = 20000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    logic [CNT_W-1:0] word_hist [ALPHABET_SIZE];
    logic [CNT_W-1:0] group_sig [MAX_GROUPS][ALPHABET_SIZE];
    int               groups_open;
    logic             saturated;
    group_result_t    expected_groups [$];
    int               error_count;
    int               idle_cycles;
    int               ready_wait = 0;
    bit               timed_out;

    anagram_group_classifier uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic void classify_char(input logic [6:0] code, input logic last);
        group_result_t r;
        int            g;
        bit            found;
        found = 0;
        r = '0;
        if (word_hist[code] >= MAX_WORD_LEN)
            saturated = 1'b1;
        else
            word_hist[code]++;
        if (!last)
            return;
        for (g = 0; g < groups_open; g++) begin
            if (group_sig[g] == word_hist) begin
                r.group_index = g[3:0];
                found = 1;
                break;
            end
        end
        if (!found) begin
            if (groups_open < MAX_GROUPS) begin
                group_sig[groups_open] = word_hist;
                r.group_index = groups_open[3:0];
                r.new_group = 1'b1;
                groups_open++;
            end
            else
                r.table_full = 1'b1;
        end
        r.word_too_long = saturated;
        expected_groups = {expected_groups, r};
        foreach (word_hist[i])
            word_hist[i] = '0;
        saturated = 1'b0;
    endfunction

    task automatic send_char(input logic [6:0] code, input logic last, input bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, code};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        classify_char(code, last);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(input logic [6:0] chars [$], input bit gaps = 1);
        for (int i = 0; i < chars.size(); i++)
            send_char(chars[i], i == chars.size() - 1, gaps);
    endtask

    task automatic wait_drained();
        while (expected_groups.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        logic [6:0] w [$];
        w = '{7'd0};
        send_word(w);
        w = '{7'd127};
        send_word(w);
        w = '{7'd65, 7'd66, 7'd67};
        send_word(w);
        w = '{7'd67, 7'd65, 7'd66};
        send_word(w);
        w = '{7'd127, 7'd0, 7'd85, 7'd42};
        send_word(w);
    endtask

    task automatic test_saturation();
        logic [6:0] w [$];
        w = {};
        repeat (66) w = {w, 7'd90};
        send_word(w, 0);
        w = {};
        repeat (63) w = {w, 7'd90};
        send_word(w, 0);
    endtask

    task automatic test_table_full();
        logic [6:0] w [$];
        for (int k = 0; k < 14; k++) begin
            w = '{7'd100, 7'(k + 1), 7'(k + 1)};
            send_word(w, 0);
        end
        w = '{7'd1, 7'd2, 7'd3, 7'd4};
        send_word(w, 0);
        w = '{7'd65, 7'd66, 7'd67};
        send_word(w);
    endtask

    task automatic test_random_words();
        logic [6:0] pool [$];
        logic [6:0] w [$];
        logic [6:0] c;
        int         len;
        for (int p = 0; p < 6; p++)
            pool = {pool, 7'($urandom_range(0, 127))};
        for (int n = 0; n < 110; n++) begin
            w = {};
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                c = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : pool[$urandom_range(0, 5)];
                w = {w, c};
            end
            if ($urandom_range(0, 2) == 0)
                w.shuffle();
            send_word(w);
            if (n == 50)
                wait_drained();
        end
    endtask

    initial begin
        error_count = 0;
        groups_open = 0;
        saturated = 1'b0;
        foreach (word_hist[i])
            word_hist[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_saturation();
        test_table_full();
        test_random_words();
        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_groups.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            ready_wait = $urandom_range(0, 17);
            m_axis_tready <= (ready_wait == 0);
        end
        else if (!m_axis_tready) begin
            if (ready_wait > 0)
                ready_wait--;
            if (ready_wait == 0)
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        group_result_t got;
        group_result_t want;
        got = '{m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[5], m_axis_tdata[6]};
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_groups.size() == 0) begin
                report_mismatch("unexpected word result", m_axis_tdata, 0);
            end
            else begin
                want = expected_groups.pop_front();
                if (got.group_index != want.group_index)
                    report_mismatch("group_index", got.group_index, want.group_index);
                if (got.new_group != want.new_group)
                    report_mismatch("new_group", got.new_group, want.new_group);
                if (got.table_full != want.table_full)
                    report_mismatch("table_full", got.table_full, want.table_full);
                if (got.word_too_long != want.word_too_long)
                    report_mismatch("word_too_long", got.word_too_long, want.word_too_long);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial idle_cycles = 0;
endmodule
`default_nettype wire
